// File: hw/rtl/pli_pkg.sv
// pli_pkg: shared codes, field widths and the cell control struct for the
// positional list. No dependencies.
`default_nettype none
package pli_pkg;

   localparam int FUNC_W = 2;
   localparam int POS_W  = 5;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 5;

   localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;
   localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

   // Broadcast to every cell: shift toward the tail (insert), shift toward
   // the head (remove), the read enable, and the 0-based slot the operation targets.
   typedef struct packed {
      logic             shift_in;
      logic             shift_out;
      logic             read_en;
      logic [POS_W-1:0] slot;
   } pli_ctl_type;

endpackage
`default_nettype wire

// File: hw/rtl/pli_decode.sv
// pli_decode: checks one request against the current length, gives the
// status, the next length and the control broadcast to the cells.
// Depends on pli_pkg.
`default_nettype none
module pli_decode #(
   parameter int DEPTH = 16,
   parameter int CNT_W = 5
) (
   input  wire logic [pli_pkg::FUNC_W-1:0] func,
   input  wire logic [pli_pkg::POS_W-1:0]  position,
   input  wire logic [CNT_W-1:0]           count,
   output pli_pkg::pli_ctl_type            ctl,
   output logic [pli_pkg::STAT_W-1:0]      status,
   output logic [CNT_W-1:0]                count_next
);
   import pli_pkg::*;

   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   logic [CMP_W-1:0] pos_e;
   logic [CMP_W-1:0] cnt_e;
   logic             pos_zero;
   logic             is_full;
   logic             is_empty;

   assign pos_e    = CMP_W'(position);
   assign cnt_e    = CMP_W'(count);
   assign pos_zero = (position == '0);
   assign is_full  = (cnt_e == DEPTH_C);
   assign is_empty = (count == '0);

   always_comb begin
      ctl.shift_in  = 1'b0;
      ctl.shift_out = 1'b0;
      ctl.read_en   = 1'b0;
      ctl.slot      = position - POS_W'(1);
      status        = ST_OK;
      count_next    = count;
      unique case (func)
         FN_INSERT: begin
            if (is_full) begin
               status = ST_FULL;
            end else if (pos_zero || pos_e > cnt_e + CMP_W'(1)) begin
               status = ST_BADPOS;
            end else begin
               ctl.shift_in = 1'b1;
               count_next   = count + CNT_W'(1);
            end
         end
         FN_REMOVE: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else if (pos_zero || pos_e > cnt_e) begin
               status = ST_BADPOS;
            end else begin
               ctl.shift_out = 1'b1;
               count_next    = count - CNT_W'(1);
            end
         end
         FN_READ: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else if (pos_zero || pos_e > cnt_e) begin
               status = ST_BADPOS;
            end else begin
               ctl.read_en = 1'b1;
            end
         end
         default: begin
            status = ST_BADPOS;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: hw/rtl/pli_cell.sv
// pli_cell: one list slot. Holds one word, takes the new word or its left or
// right neighbor's word on a shift, and taps its word out on a matching read.
// Depends on pli_pkg.
`default_nettype none
module pli_cell #(
   parameter int DATA_W  = 32,
   parameter int INDEX_W = 5,
   parameter int INDEX   = 0
) (
   input  wire logic              clock,
   input  wire pli_pkg::pli_ctl_type ctl,
   input  wire logic [DATA_W-1:0] new_word,
   input  wire logic [DATA_W-1:0] left_word,
   input  wire logic [DATA_W-1:0] right_word,
   output logic [DATA_W-1:0]      word,
   output logic [DATA_W-1:0]      tap
);
   import pli_pkg::*;

   localparam logic [INDEX_W-1:0] MY_IDX = INDEX_W'(INDEX);

   logic [DATA_W-1:0]  word_ff;
   logic [DATA_W-1:0]  word_in;
   logic [INDEX_W-1:0] slot_e;
   logic               hit;
   logic               past;

   assign slot_e = INDEX_W'(ctl.slot);
   assign hit    = (slot_e == MY_IDX);
   assign past   = (MY_IDX > slot_e);

   always_comb begin
      word_in = word_ff;
      if (ctl.shift_in) begin
         if (hit) begin
            word_in = new_word;
         end else if (past) begin
            word_in = left_word;
         end
      end else if (ctl.shift_out) begin
         if (hit || past) begin
            word_in = right_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   assign tap  = (ctl.read_en && hit) ? word_ff : '0;

endmodule
`default_nettype wire

// File: hw/rtl/positional_list_insert_remove.sv
// positional_list_insert_remove: ordered list of DEPTH words by 1-based rank
// with insert, remove and read. The result is registered and its beat follows in
// the cycle after the request beat. Throughput: one request per cycle unless the
// response is held back; the whole row of cells shifts in the same edge, and the
// output register frees req_tready while a result is taken. Reset clears the length and
// the output valid; cell contents are undefined until written. Depends on pli_pkg, pli_decode, pli_cell.
`default_nettype none
module positional_list_insert_remove #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // tdata, low bit up: position[4:0], entry_data[DATA_W-1:0], zero pad
   input  wire logic [((pli_pkg::POS_W + DATA_W + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: func[1:0]
   input  wire logic [pli_pkg::FUNC_W-1:0]     req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // tdata, low bit up: status[1:0], read_data[DATA_W-1:0], list_length[4:0], zero pad
   output logic [((pli_pkg::STAT_W + DATA_W + pli_pkg::LEN_W + 7) / 8) * 8 - 1:0] rsp_tdata
);
   import pli_pkg::*;

   localparam int RSP_W   = ((STAT_W + DATA_W + LEN_W + 7) / 8) * 8;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int INDEX_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   // request fields
   logic [POS_W-1:0]  req_pos;
   logic [DATA_W-1:0] req_word;
   logic              req_beat;

   assign req_pos  = req_tdata[POS_W-1:0];
   assign req_word = req_tdata[POS_W +: DATA_W];

   // the output register is free when empty or being drained this cycle
   assign req_tready = !rsp_tvalid || rsp_tready;
   assign req_beat   = req_tvalid && req_tready;

   // length register and decode
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  count_next;
   logic [STAT_W-1:0] dec_status;
   pli_ctl_type       dec_ctl;
   pli_ctl_type       cell_ctl;

   pli_decode #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_decode (
      .func       (req_tuser),
      .position   (req_pos),
      .count      (count_ff),
      .ctl        (dec_ctl),
      .status     (dec_status),
      .count_next (count_next)
   );

   // cells act only on an accepted beat
   always_comb begin
      cell_ctl           = dec_ctl;
      cell_ctl.shift_in  = dec_ctl.shift_in && req_beat;
      cell_ctl.shift_out = dec_ctl.shift_out && req_beat;
      cell_ctl.read_en   = dec_ctl.read_en && req_beat;
   end

   assign count_in = req_beat ? count_next : count_ff;

   // row of cells; each neighbors its left and right cell
   logic [DATA_W-1:0] cell_word [DEPTH];
   logic [DATA_W-1:0] cell_tap  [DEPTH];

   for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;
      if (gi == 0) begin : g_head
         assign left_w = cell_word[gi];
      end else begin : g_mid_l
         assign left_w = cell_word[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_tail
         assign right_w = cell_word[gi];
      end else begin : g_mid_r
         assign right_w = cell_word[gi+1];
      end
      pli_cell #(
         .DATA_W  (DATA_W),
         .INDEX_W (INDEX_W),
         .INDEX   (gi)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .new_word   (req_word),
         .left_word  (left_w),
         .right_word (right_w),
         .word       (cell_word[gi]),
         .tap        (cell_tap[gi])
      );
   end

   // at most one cell taps its word, so OR the taps together
   logic [DATA_W-1:0] read_word;
   always_comb begin
      read_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_word = read_word | cell_tap[i];
      end
   end

   // output register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [LEN_W-1:0]  rsp_len_ff;

   assign rsp_valid_in = req_beat || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         rsp_status_ff <= dec_status;
         rsp_data_ff   <= read_word;
         rsp_len_ff    <= LEN_W'(count_next);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_len_ff, rsp_data_ff, rsp_status_ff});

   // checks
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("list length above DEPTH");

   a_beat_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> rsp_valid_ff)
      else $error("accepted beat without response");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (req_beat && dec_ctl.shift_in) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the list");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_data_ff == '0))
      else $error("failed operation returned data");

endmodule
`default_nettype wire

// File: sim/pli_list_checker.sv
// pli_list_checker: watches the request and response streams of the positional
// list, keeps its own copy of the list, and checks every response beat.
// Depends on pli_pkg for field widths, operation and status codes.
module pli_list_checker #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 32,
   parameter int REQ_W  = ((pli_pkg::POS_W + DATA_W + 7) / 8) * 8,
   parameter int RSP_W  = ((pli_pkg::STAT_W + DATA_W + pli_pkg::LEN_W + 7) / 8) * 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   input  wire logic                       req_tready,
   // position[4:0], entry_data, zero pad
   input  wire logic [REQ_W-1:0]           req_tdata,
   // func[1:0]
   input  wire logic [pli_pkg::FUNC_W-1:0] req_tuser,
   input  wire logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   // status[1:0], read_data, list_length[4:0], zero pad
   input  wire logic [RSP_W-1:0]           rsp_tdata,
   output int                              fail_count,
   output int                              pending,
   output int                              checked_count,
   output int                              ok_count,
   output int                              full_count,
   output int                              empty_count,
   output int                              badpos_count
);
   import pli_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] read_data;
      logic [LEN_W-1:0]  length;
   } list_result_type;

   logic [DATA_W-1:0] mirror_words [DEPTH];
   int                mirror_len;
   list_result_type   awaited_rsp [$];
   int                fails;
   int                checked;
   int                status_tally [4];

   // Apply one operation to the mirror list and return the response it gives.
   function automatic list_result_type apply_list_op(logic [FUNC_W-1:0] fn,
                                                     logic [POS_W-1:0] rank,
                                                     logic [DATA_W-1:0] word);
      list_result_type res;
      int              r;
      int              i;
      r = rank;
      res.status    = ST_OK;
      res.read_data = '0;
      case (fn)
         FN_INSERT: begin
            if (mirror_len >= DEPTH) begin
               res.status = ST_FULL;
            end else if (r < 1 || r > mirror_len + 1) begin
               res.status = ST_BADPOS;
            end else begin
               for (i = mirror_len; i >= r; i--) mirror_words[i] = mirror_words[i-1];
               mirror_words[r-1] = word;
               mirror_len++;
            end
         end
         FN_REMOVE: begin
            if (mirror_len == 0) begin
               res.status = ST_EMPTY;
            end else if (r < 1 || r > mirror_len) begin
               res.status = ST_BADPOS;
            end else begin
               for (i = r; i < mirror_len; i++) mirror_words[i-1] = mirror_words[i];
               mirror_len--;
            end
         end
         FN_READ: begin
            if (mirror_len == 0) begin
               res.status = ST_EMPTY;
            end else if (r < 1 || r > mirror_len) begin
               res.status = ST_BADPOS;
            end else begin
               res.read_data = mirror_words[r-1];
            end
         end
         default: res.status = ST_BADPOS;
      endcase
      res.length = LEN_W'(mirror_len);
      return res;
   endfunction

   initial begin
      fails   = 0;
      checked = 0;
      foreach (status_tally[k]) status_tally[k] = 0;
   end

   always @(posedge clock) begin
      list_result_type want;
      list_result_type got;
      if (reset) begin
         awaited_rsp.delete();
         mirror_len = 0;
      end else begin
         // response first: it always belongs to an earlier request beat
         if (rsp_tvalid && rsp_tready) begin
            got.status    = rsp_tdata[STAT_W-1:0];
            got.read_data = rsp_tdata[STAT_W +: DATA_W];
            got.length    = rsp_tdata[STAT_W + DATA_W +: LEN_W];
            if (awaited_rsp.size() == 0) begin
               if (fails < 10)
                  $display("unexpected response beat: status %0d read_data %h length %0d",
                           got.status, got.read_data, got.length);
               fails++;
            end else begin
               want = awaited_rsp.pop_front();
               checked++;
               status_tally[want.status]++;
               if (got.status !== want.status || got.read_data !== want.read_data ||
                   got.length !== want.length) begin
                  if (fails < 10)
                     $display({"mismatch on response %0d: status exp %0d got %0d, ",
                               "read_data exp %h got %h, length exp %0d got %0d"},
                              checked, want.status, got.status, want.read_data,
                              got.read_data, want.length, got.length);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready)
            awaited_rsp.push_back(apply_list_op(req_tuser, req_tdata[POS_W-1:0],
                                                req_tdata[POS_W +: DATA_W]));
      end
      fail_count    <= fails;
      pending       <= awaited_rsp.size();
      checked_count <= checked;
      ok_count      <= status_tally[ST_OK];
      full_count    <= status_tally[ST_FULL];
      empty_count   <= status_tally[ST_EMPTY];
      badpos_count  <= status_tally[ST_BADPOS];
   end

endmodule

// File: sim/positional_list_insert_remove_tb.sv
// positional_list_insert_remove_tb: drives request beats into the positional
// list and throttles its response stream; verdict from pli_list_checker.
// Depends on pli_pkg, pli_list_checker and the positional list RTL.
module positional_list_insert_remove_tb;
   import pli_pkg::*;

   localparam int DEPTH       = 16;
   localparam int DATA_W      = 32;
   localparam int REQ_W       = ((POS_W + DATA_W + 7) / 8) * 8;
   localparam int RSP_W       = ((STAT_W + DATA_W + LEN_W + 7) / 8) * 8;
   localparam int TOTAL_BEATS = 450;
   // Worst legal spacing between two accepted beats is the longest send gap
   // plus the longest response stall plus the result latency; this is far
   // beyond that.
   localparam int STALL_LIMIT = 2000;

   typedef enum logic [1:0] {SEQ_FILL, SEQ_CHURN, SEQ_DRAIN} seq_kind_type;

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;   // position[4:0], entry_data[31:0], zero pad
   logic [FUNC_W-1:0]  req_tuser  = '0;   // func[1:0]
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;         // status[1:0], read_data[31:0], list_length[4:0], pad

   int fail_count, pending, checked_count;
   int ok_count, full_count, empty_count, badpos_count;

   int beats_sent   = 0;
   int est_len      = 0;    // length the list should have; only steers stimulus
   bit sender_steady = 1'b0; // when set, request beats go back to back
   int idle_cycles  = 0;

   positional_list_insert_remove #(
      .DEPTH (DEPTH),
      .DATA_W(DATA_W)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   pli_list_checker #(
      .DEPTH (DEPTH),
      .DATA_W(DATA_W)
   ) u_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked_count(checked_count),
      .ok_count     (ok_count),
      .full_count   (full_count),
      .empty_count  (empty_count),
      .badpos_count (badpos_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // One request beat: optional idle gap, then hold valid until taken.
   // With no gap, valid simply stays high and only the payload changes.
   task automatic send_beat(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] rank,
                            input logic [DATA_W-1:0] word);
      logic [REQ_W-1:0] beat;
      int               gap;
      int               r;
      gap = sender_steady ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      beat                 = '0;
      beat[POS_W-1:0]      = rank;
      beat[POS_W +: DATA_W] = word;
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      req_tuser  <= fn;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
      // track the length so the random part can aim at legal ranks
      r = rank;
      case (fn)
         FN_INSERT: if (est_len < DEPTH && r >= 1 && r <= est_len + 1) est_len++;
         FN_REMOVE: if (est_len > 0 && r >= 1 && r <= est_len) est_len--;
         default: ;
      endcase
   endtask

   // Response side: per beat a random stall, with stretches of no stall.
   initial begin
      int  stall;
      int  left;
      bit  steady;
      left   = 0;
      steady = 1'b0;
      forever begin
         if (left == 0) begin
            left   = $urandom_range(8, 40);
            steady = ($urandom_range(0, 3) == 0);
         end
         left--;
         stall = steady ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog: any accepted beat on either side resets the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, pending);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      seq_kind_type      kind;
      int                seq_idx;
      int                seq_len;
      int                directed_beats;
      int                ins_pct;
      int                rm_pct;
      int                roll;
      logic [FUNC_W-1:0] fn;
      logic [POS_W-1:0]  rank;
      logic [DATA_W-1:0] word;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part: empty list, rank edges, head/middle/tail, unused func
      send_beat(FN_READ,   5'd1,  32'h1234_5678);  // read on empty
      send_beat(FN_REMOVE, 5'd0,  '0);             // empty wins over bad rank
      send_beat(FN_NONE,   5'd1,  '1);             // unused code on empty list
      send_beat(FN_INSERT, 5'd0,  32'hDEAD_BEEF);  // rank zero
      send_beat(FN_INSERT, 5'd2,  32'hDEAD_BEEF);  // beyond length+1
      send_beat(FN_INSERT, 5'd1,  32'h0000_0000);  // first entry, all-zero word
      send_beat(FN_INSERT, 5'd2,  32'hFFFF_FFFF);  // append at tail
      send_beat(FN_INSERT, 5'd1,  32'hA5A5_A5A5);  // insert at head
      send_beat(FN_INSERT, 5'd2,  32'h5A5A_5A5A);  // insert in the middle
      send_beat(FN_READ,   5'd4,  '0);             // last entry
      send_beat(FN_READ,   5'd1,  '0);             // first entry
      send_beat(FN_READ,   5'd5,  '0);             // one past the end
      send_beat(FN_READ,   5'd0,  '0);             // rank zero
      send_beat(FN_READ,   5'd31, '0);             // top rank value
      send_beat(FN_INSERT, 5'd31, 32'h0F0F_0F0F);  // top rank on insert
      send_beat(FN_REMOVE, 5'd31, '0);             // top rank on remove
      send_beat(FN_REMOVE, 5'd2,  '0);             // close a gap in the middle
      send_beat(FN_READ,   5'd2,  '0);
      send_beat(FN_NONE,   5'd2,  '0);             // unused code, list not empty
      send_beat(FN_REMOVE, 5'd3,  '0);             // remove the tail
      send_beat(FN_REMOVE, 5'd1,  '0);
      send_beat(FN_REMOVE, 5'd1,  '0);             // back to empty
      directed_beats = beats_sent;

      // ---- random part: sequences that fill, churn or drain the list,
      // mostly with legal ranks; a share of beats is pure noise.
      seq_idx = 0;
      while (beats_sent < TOTAL_BEATS) begin
         case (seq_idx % 4)
            0:       kind = SEQ_FILL;
            2:       kind = SEQ_DRAIN;
            default: kind = SEQ_CHURN;
         endcase
         seq_idx++;
         seq_len       = (kind == SEQ_FILL) ? $urandom_range(24, 48) : $urandom_range(8, 40);
         sender_steady = ($urandom_range(0, 3) == 0);
         ins_pct = (kind == SEQ_FILL) ? 80 : (kind == SEQ_DRAIN) ? 15 : 40;
         rm_pct  = (kind == SEQ_FILL) ? 10 : (kind == SEQ_DRAIN) ? 70 : 30;
         repeat (seq_len) begin
            if ($urandom_range(0, 99) < 12) begin
               fn   = FUNC_W'($urandom_range(0, 3));
               rank = POS_W'($urandom_range(0, 31));
            end else begin
               roll = $urandom_range(0, 99);
               if (roll < ins_pct)               fn = FN_INSERT;
               else if (roll < ins_pct + rm_pct) fn = FN_REMOVE;
               else                              fn = FN_READ;
               if (fn == FN_INSERT)
                  rank = POS_W'($urandom_range(1, est_len + 1));   // full list still hits here
               else if (est_len == 0)
                  rank = POS_W'($urandom_range(0, 31));
               else
                  rank = POS_W'($urandom_range(1, est_len));
            end
            case ($urandom_range(0, 9))
               0:       word = '0;
               1:       word = '1;
               default: word = DATA_W'($urandom);
            endcase
            send_beat(fn, rank, word);
         end
      end

      req_tvalid    <= 1'b0;
      sender_steady  = 1'b0;

      // pending is registered in the checker, so let the last push land before polling it
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d request beats (%0d directed), checked %0d response beats.",
               beats_sent, directed_beats, checked_count);
      $display("Status mix: ok %0d, full %0d, empty %0d, bad position %0d.",
               ok_count, full_count, empty_count, badpos_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d failing response beats", fail_count);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/pli_pkg.sv
hw/rtl/pli_decode.sv
hw/rtl/pli_cell.sv
hw/rtl/positional_list_insert_remove.sv
sim/pli_list_checker.sv
sim/positional_list_insert_remove_tb.sv
